// ===== design/albc_pkg.sv =====
package albc_pkg;

    // Default depth of the target history ring
    localparam int HISTORY_LEN_DEF = 8;

    // Field and register widths
    localparam int LEVEL_W = 8;
    localparam int LUX_W   = 16;
    localparam int Q_W     = 16;
    localparam int LOG_W   = 12;
    localparam int QUOT_W  = 8;

    // Item operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SEED   = 1'b1;

    // Register indexes on the configuration port
    localparam logic REG_MIN_LEVEL = 1'b0;
    localparam logic REG_MAX_LEVEL = 1'b1;

    // Reset values of the registers
    localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 8'd0;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 8'd255;

    // 2^20 / log2(10000) per Q4.8 unit of log2
    localparam logic [16:0] LOG_SCALE_K     = 17'd78913;
    localparam int          LOG_SCALE_SHIFT = 20;

    // round(256 * log2(1 + i/32))
    localparam logic [7:0] LOG_FRAC_TAB [32] = '{
        8'd0,   8'd11,  8'd22,  8'd33,  8'd44,  8'd54,  8'd63,  8'd73,
        8'd82,  8'd92,  8'd100, 8'd109, 8'd118, 8'd126, 8'd134, 8'd142,
        8'd150, 8'd157, 8'd165, 8'd172, 8'd179, 8'd186, 8'd193, 8'd200,
        8'd207, 8'd213, 8'd220, 8'd226, 8'd232, 8'd238, 8'd244, 8'd250
    };

    // log2 of a nonzero value in Q4.8: leading-one index plus fraction table
    function automatic logic [LOG_W-1:0] log2_q4_8(input logic [LUX_W-1:0] x);
        logic [3:0]       e;
        logic [LUX_W-1:0] m;
        e = 4'd0;
        for (int k = 0; k < LUX_W; k++)
        begin
            if (x[k])
                e = 4'(k);
        end
        m = x << (4'd15 - e);
        return {e, 8'h00} + {4'h0, LOG_FRAC_TAB[m[14:10]]};
    endfunction

endpackage

// ===== design/ambient_light_backlight_control.sv =====
// Ambient light to backlight level controller.
// Input channel (in_valid/in_stall): one transaction per sensor sample (op 0,
// lux) or per seed (op 1, seed_level read back from the panel).
// Output channel (out_valid/out_stall): exactly one transaction per input,
// carrying level and write_enable; write_enable marks a level the host must
// write and poll faster on.
// min_level and max_level are written over the APB port at 0x0 and 0x4; a
// change takes effect at the next sample with a new lux value.
// A seed goes straight to the done step. A sample passes the log step, then the
// two multiply steps for a new nonzero lux with max above min, then the ring
// update and the compare, and the divide when the level moves.
// One item is in work at a time and the next is taken in the cycle after its
// result is registered, so the block takes no new item before it is through
// with the last one.
// in_stall is high while an item is in work. A result that the receiver
// stalls is held in the output register; the next item is still accepted and
// its result waits behind it, with in_stall high until the register frees.
// Reset clears the history ring to zero, the current level to zero and the registers
// to 0 and 255.
module ambient_light_backlight_control #(
    parameter int HISTORY_LEN = albc_pkg::HISTORY_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Item input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [albc_pkg::LUX_W-1:0]    lux,
    input  logic [albc_pkg::LEVEL_W-1:0]  seed_level,
    // Result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [albc_pkg::LEVEL_W-1:0]  level,
    output logic                          write_enable,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import albc_pkg::*;

    localparam int SUM_W  = 16 + $clog2(HISTORY_LEN);
    localparam int SLOT_W = $clog2(HISTORY_LEN);
    localparam int P1_W   = LEVEL_W + LOG_W;
    localparam int P2_W   = P1_W + 17;
    localparam int PART_W = P2_W - LOG_SCALE_SHIFT;

    localparam logic [SUM_W-1:0]  N_CONST  = SUM_W'(HISTORY_LEN);
    localparam logic [SUM_W-1:0]  N256     = SUM_W'(HISTORY_LEN * 256);
    localparam logic [SUM_W-1:0]  SUM_MAX  = SUM_W'(HISTORY_LEN * 65280);
    localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(HISTORY_LEN - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOG   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SCALE = 3'd3;
    localparam logic [2:0] S_RING  = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [LEVEL_W-1:0] min_reg, max_reg;
    logic [LUX_W-1:0]   lux_reg, lux_next;
    logic [LUX_W-1:0]   prev_lux_reg, prev_lux_next;
    logic [Q_W-1:0]     target_reg, target_next;
    logic [Q_W-1:0]     fill_reg, fill_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [LEVEL_W-1:0] cur_lvl_reg, cur_lvl_next;
    logic               we_reg, we_next;
    logic [P1_W-1:0]    prod1_reg, prod1_next;
    logic [P2_W-1:0]    prod2_reg, prod2_next;
    logic [HISTORY_LEN-1:0] vld_reg, vld_next;
    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               write_enable_reg, write_enable_next;

    logic [Q_W-1:0]     hist_mem [HISTORY_LEN];
    logic [Q_W-1:0]     rd_data_reg;
    logic               mem_we;

    logic               in_acc;
    logic               out_free;
    logic [LEVEL_W-1:0] span;
    logic [LOG_W-1:0]   log_val;
    logic [PART_W-1:0]  part;
    logic [Q_W-1:0]     old_entry;
    logic [SUM_W-1:0]   cur_scaled;
    logic [SUM_W-1:0]   diff;
    logic               div_start;
    logic               div_done;
    logic [QUOT_W-1:0]  div_quot;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign span     = max_reg - min_reg;
    assign log_val  = log2_q4_8(lux_reg);
    assign part     = prod2_reg[P2_W-1:LOG_SCALE_SHIFT];
    assign old_entry = vld_reg[slot_reg] ? rd_data_reg : fill_reg;
    assign cur_scaled = SUM_W'({cur_lvl_reg, 8'h00}) * N_CONST;
    assign diff = (cur_scaled > sum_reg) ? (cur_scaled - sum_reg) : (sum_reg - cur_scaled);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_LEVEL_RST;
            max_reg <= MAX_LEVEL_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_MIN_LEVEL: min_reg <= pwdata[LEVEL_W-1:0];
                REG_MAX_LEVEL: max_reg <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MIN_LEVEL: prdata = {24'h0, min_reg};
            REG_MAX_LEVEL: prdata = {24'h0, max_reg};
            default:       prdata = 32'h0;
        endcase
    end

    assign pready = 1'b1;

    // History ring storage with registered read at the current slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[slot_reg] <= target_reg;
        rd_data_reg <= hist_mem[slot_reg];
    end

    // Mean divider
    albc_div #(
        .HISTORY_LEN(HISTORY_LEN),
        .SUM_W      (SUM_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(sum_reg),
        .done    (div_done),
        .quotient(div_quot)
    );

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        lux_next          = lux_reg;
        prev_lux_next     = prev_lux_reg;
        target_next       = target_reg;
        fill_next         = fill_reg;
        sum_next          = sum_reg;
        slot_next         = slot_reg;
        cur_lvl_next      = cur_lvl_reg;
        we_next           = we_reg;
        prod1_next        = prod1_reg;
        prod2_next        = prod2_reg;
        vld_next          = vld_reg;
        out_valid_next    = out_valid_reg && out_stall;
        level_next        = level_reg;
        write_enable_next = write_enable_reg;
        mem_we            = 1'b0;
        div_start         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (op == OP_SEED)
                    begin
                        // Seed: the whole ring reads as the seed through the fill value
                        target_next   = {seed_level, 8'h00};
                        fill_next     = {seed_level, 8'h00};
                        vld_next      = '0;
                        sum_next      = SUM_W'({seed_level, 8'h00}) * N_CONST;
                        cur_lvl_next  = seed_level;
                        prev_lux_next = '0;
                        slot_next     = '0;
                        we_next       = 1'b0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        lux_next   = lux;
                        state_next = S_LOG;
                    end
                end
            end
            S_LOG:
            begin
                if (lux_reg == prev_lux_reg)
                    state_next = S_RING;
                else
                begin
                    prev_lux_next = lux_reg;
                    if (lux_reg == '0 || max_reg <= min_reg)
                    begin
                        target_next = {min_reg, 8'h00};
                        state_next  = S_RING;
                    end
                    else
                    begin
                        prod1_next = P1_W'(span) * P1_W'(log_val);
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod2_next = P2_W'(prod1_reg) * P2_W'(LOG_SCALE_K);
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                // Saturate the scaled part at the span
                if (part > PART_W'({span, 8'h00}))
                    target_next = {max_reg, 8'h00};
                else
                    target_next = {min_reg, 8'h00} + part[Q_W-1:0];
                state_next = S_RING;
            end
            S_RING:
            begin
                // Replace the oldest entry and advance the slot
                sum_next = sum_reg - SUM_W'(old_entry) + SUM_W'(target_reg);
                mem_we   = 1'b1;
                vld_next[slot_reg] = 1'b1;
                slot_next  = (slot_reg == SLOT_TOP) ? '0 : slot_reg + 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (diff > N256)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    we_next    = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    cur_lvl_next = div_quot;
                    we_next      = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    level_next        = cur_lvl_reg;
                    write_enable_next = we_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_lux_reg  <= '0;
            target_reg    <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            slot_reg      <= '0;
            cur_lvl_reg   <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_lux_reg  <= prev_lux_next;
            target_reg    <= target_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            slot_reg      <= slot_next;
            cur_lvl_reg   <= cur_lvl_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lux_reg          <= lux_next;
        we_reg           <= we_next;
        prod1_reg        <= prod1_next;
        prod2_reg        <= prod2_next;
        level_reg        <= level_next;
        write_enable_reg <= write_enable_next;
    end

    assign out_valid    = out_valid_reg;
    assign level        = level_reg;
    assign write_enable = write_enable_reg;

`ifndef ASSERT_OFF
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide step");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_MAX)
        else $error("history sum above the ring maximum");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_TOP)
        else $error("history slot out of range");

    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished transaction not moved to the output register");
`endif

endmodule

// ===== design/albc_div.sv =====
module albc_div #(
    parameter int HISTORY_LEN = albc_pkg::HISTORY_LEN_DEF,
    parameter int SUM_W       = 16 + $clog2(HISTORY_LEN)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [SUM_W-1:0]           dividend,
    output logic                       done,
    output logic [albc_pkg::QUOT_W-1:0] quotient
);
    import albc_pkg::*;

    localparam int SLOT_W  = $clog2(HISTORY_LEN);
    localparam int X_W     = SUM_W - 8;
    localparam int SHIFT   = 8 + 2 * SLOT_W;
    localparam int RECIP_W = 10 + SLOT_W;
    localparam int PROD_W  = X_W + RECIP_W;
    // ceil(2^SHIFT / N): gives the exact floor of x / N for every x of X_W bits
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << SHIFT) + HISTORY_LEN - 1) / HISTORY_LEN);

    logic              done_reg;
    logic [PROD_W-1:0] prod_reg;

    // Flag the quotient in the cycle after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= start;
    end

    // Divide by 256*N: drop the low byte, then multiply by the reciprocal of N
    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= PROD_W'(dividend[SUM_W-1:8]) * PROD_W'(RECIP);
    end

    assign done     = done_reg;
    assign quotient = prod_reg[SHIFT +: QUOT_W];

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import albc_pkg::*;

    localparam int HIST_N   = HISTORY_LEN_DEF;
    localparam int MEAN_DIV = 256 * HIST_N;

    typedef struct {
        logic                op;
        logic [LUX_W-1:0]    lux;
        logic [LEVEL_W-1:0]  seed_level;
    } light_item_t;

    typedef struct {
        logic [LEVEL_W-1:0]  level;
        logic                write_enable;
    } level_update_t;

    // Clock, reset and block ports
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                op = OP_SAMPLE;
    logic [LUX_W-1:0]    lux = '0;
    logic [LEVEL_W-1:0]  seed_level = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [LEVEL_W-1:0]  level;
    logic                write_enable;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Stimulus and scoreboard
    light_item_t         pending_items[$];
    level_update_t       expected_updates[$];
    bit                  in_taken;
    int                  fail_count;
    int                  results_seen;
    int                  gap_pct;
    int                  stall_pct;
    bit                  quiet_tail;
    int                  send_gap;
    int                  stall_left;
    int                  hold_left;
    bit                  long_hold_done;
    logic [LUX_W-1:0]    last_queued_lux;

    // Predicted block state
    logic [LEVEL_W-1:0]  cfg_min = MIN_LEVEL_RST;
    logic [LEVEL_W-1:0]  cfg_max = MAX_LEVEL_RST;
    logic [Q_W-1:0]      ring [HIST_N];
    logic [18:0]         ring_sum;
    int unsigned         ring_slot;
    logic [LUX_W-1:0]    last_lux;
    logic [Q_W-1:0]      target_q;
    logic [LEVEL_W-1:0]  shown_level;

    always #6 clk = ~clk;

    ambient_light_backlight_control #(
        .HISTORY_LEN(HIST_N)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .lux(lux),
        .seed_level(seed_level),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .level(level),
        .write_enable(write_enable),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // log2 in Q4.8: position of the top set bit plus the fraction lookup
    function automatic logic [LOG_W-1:0] lux_log2(input logic [LUX_W-1:0] x);
        int               msb;
        logic [LUX_W-1:0] norm;
        msb = LUX_W - 1;
        while (msb > 0 && !x[msb])
            msb--;
        norm = x << (LUX_W - 1 - msb);
        return LOG_W'(msb * 256 + LOG_FRAC_TAB[norm[14:10]]);
    endfunction

    // Brightness target in Q8.8 for a new lux value
    function automatic logic [Q_W-1:0] lux_target(input logic [LUX_W-1:0] x);
        logic [Q_W-1:0]  lo;
        logic [Q_W-1:0]  hi;
        longint unsigned span;
        longint unsigned lg;
        longint unsigned part;
        lo = {cfg_min, 8'h00};
        hi = {cfg_max, 8'h00};
        if (x == '0 || cfg_max <= cfg_min)
            return lo;
        span = cfg_max - cfg_min;
        lg   = lux_log2(x);
        part = (span * lg * LOG_SCALE_K) >> LOG_SCALE_SHIFT;
        if (part > hi - lo)
            return hi;
        return Q_W'(lo + part);
    endfunction

    // Advance the predicted state by one transaction and return its result
    function automatic level_update_t backlight_step(input light_item_t it);
        level_update_t r;
        logic [18:0]   scaled;
        logic [18:0]   gap;
        r.write_enable = 1'b0;
        if (it.op == OP_SEED)
        begin
            foreach (ring[i])
                ring[i] = {it.seed_level, 8'h00};
            ring_sum    = 19'(HIST_N * {it.seed_level, 8'h00});
            target_q    = {it.seed_level, 8'h00};
            shown_level = it.seed_level;
            last_lux    = '0;
            ring_slot   = 0;
        end
        else
        begin
            if (it.lux != last_lux)
            begin
                last_lux = it.lux;
                target_q = lux_target(it.lux);
            end
            ring_sum        = ring_sum - ring[ring_slot] + target_q;
            ring[ring_slot] = target_q;
            ring_slot       = (ring_slot + 1) % HIST_N;
            scaled = 19'(shown_level * MEAN_DIV);
            gap    = (scaled > ring_sum) ? scaled - ring_sum : ring_sum - scaled;
            if (gap > MEAN_DIV)
            begin
                shown_level    = LEVEL_W'(ring_sum / MEAN_DIV);
                r.write_enable = 1'b1;
            end
        end
        r.level = shown_level;
        return r;
    endfunction

    // Check results, then predict for the transaction accepted at this edge
    always @(posedge clk)
    begin
        level_update_t want;
        light_item_t   got_item;
        in_taken = rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_updates.size() == 0)
            begin
                $error("unexpected result: level %0d write_enable %0b", level, write_enable);
                fail_count++;
            end
            else
            begin
                want = expected_updates.pop_front();
                if (level !== want.level)
                begin
                    $error("level: expected %0d, actual %0d", want.level, level);
                    fail_count++;
                end
                if (write_enable !== want.write_enable)
                begin
                    $error("write_enable: expected %0b, actual %0b",
                           want.write_enable, write_enable);
                    fail_count++;
                end
            end
        end
        if (in_taken)
        begin
            got_item.op         = op;
            got_item.lux        = lux;
            got_item.seed_level = seed_level;
            expected_updates.push_back(backlight_step(got_item));
        end
    end

    // Input driver: hold a stalled transaction, otherwise advance or idle
    always @(negedge clk)
    begin
        light_item_t it;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                op         <= it.op;
                lux        <= it.lux;
                seed_level <= it.seed_level;
                in_valid   <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 99) < gap_pct)
                    send_gap = $urandom_range(1, 17);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall: random bursts plus one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!long_hold_done && results_seen >= 150)
        begin
            long_hold_done = 1'b1;
            hold_left      = 400;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!quiet_tail && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 17);
        end
    end

    task automatic queue_sample(input logic [LUX_W-1:0] value);
        light_item_t it;
        it.op           = OP_SAMPLE;
        it.lux          = value;
        it.seed_level   = LEVEL_W'($urandom);
        last_queued_lux = value;
        pending_items.push_back(it);
    endtask

    task automatic queue_seed(input logic [LEVEL_W-1:0] value);
        light_item_t it;
        it.op         = OP_SEED;
        it.lux        = LUX_W'($urandom);
        it.seed_level = value;
        pending_items.push_back(it);
    endtask

    // Mostly samples over all magnitudes, with repeats, zero lux and seeds
    task automatic queue_random(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                queue_seed(LEVEL_W'($urandom_range(0, 255)));
            else if (r < 24)
                queue_sample(last_queued_lux);
            else if (r < 30)
                queue_sample('0);
            else
                queue_sample(LUX_W'($urandom_range(0, 65535) >> $urandom_range(0, 15)));
        end
    endtask

    // Wait until every transaction has been sent and answered
    task automatic drain_results();
        do
            @(posedge clk);
        while (pending_items.size() > 0 || in_valid || expected_updates.size() > 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [LEVEL_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {24'h0, value};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_MIN_LEVEL)
            cfg_min = value;
        else
            cfg_max = value;
    endtask

    task automatic set_levels(input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi);
        drain_results();
        apb_write(REG_MIN_LEVEL, lo);
        apb_write(REG_MAX_LEVEL, hi);
        gap_pct   = 15 * $urandom_range(0, 2);
        stall_pct = 15 * $urandom_range(0, 2);
    endtask

    // Stimulus sequence
    initial
    begin
        logic [LEVEL_W-1:0] a;
        logic [LEVEL_W-1:0] b;
        logic [LEVEL_W-1:0] t;
        foreach (ring[i])
            ring[i] = '0;
        ring_sum    = '0;
        ring_slot   = 0;
        last_lux    = '0;
        target_q    = '0;
        shown_level = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset levels, no idling
        queue_sample(16'd0);
        queue_sample(16'd1);
        queue_sample(16'd2);
        queue_sample(16'd3);
        queue_sample(16'd10000);
        queue_sample(16'd10000);
        queue_sample(16'hFFFF);
        queue_sample(16'hFFFF);
        queue_sample(16'hFFFF);
        queue_seed(8'd255);
        queue_sample(16'd0);
        queue_sample(16'hFFFF);
        queue_seed(8'd0);
        queue_sample(16'h8000);
        queue_sample(16'd1);
        queue_sample(16'd0);
        queue_seed(8'd128);
        queue_sample(16'd100);
        queue_sample(16'd100);
        queue_sample(16'hAAAA);
        queue_sample(16'h5555);
        queue_sample(16'd9999);

        // Max below min, equal extremes, then full range again
        set_levels(8'd255, 8'd0);
        queue_sample(last_queued_lux);
        queue_random(40);
        set_levels(8'd0, 8'd0);
        queue_random(40);
        set_levels(8'd255, 8'd255);
        queue_random(40);
        set_levels(8'd0, 8'd255);
        queue_sample(last_queued_lux);
        queue_random(100);

        // Random level ranges, mostly well ordered
        repeat (6)
        begin
            a = LEVEL_W'($urandom_range(0, 255));
            b = LEVEL_W'($urandom_range(0, 255));
            if (a > b && $urandom_range(0, 3) != 0)
            begin
                t = a;
                a = b;
                b = t;
            end
            set_levels(a, b);
            queue_random(60);
        end

        // Final stretch with no idling on either side
        set_levels(8'd1, 8'd254);
        quiet_tail = 1'b1;
        queue_random(60);
        drain_results();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #6_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
